>>> sv/nvpt_pkg.sv
`timescale 1ns / 1ps
// shared types and character constants for the name/value pair tokenizer
// no dependencies

package nvpt_pkg;

    typedef enum logic [3:0] {
        PH_KEYSPACE = 4'd0,
        PH_KEY      = 4'd1,
        PH_EQSPACE  = 4'd2,
        PH_EQUAL    = 4'd3,
        PH_DQ       = 4'd4,
        PH_SQ       = 4'd5,
        PH_RAW      = 4'd6,
        PH_AFTER    = 4'd7,
        PH_INVALID  = 4'd8,
        PH_FINISHED = 4'd9
    } t_phase;

    typedef enum logic [1:0] {
        ROLE_NONE  = 2'd0,
        ROLE_KEY   = 2'd1,
        ROLE_VALUE = 2'd2
    } t_role;

    typedef enum logic [1:0] {
        PAIR_NONE     = 2'd0,
        PAIR_VALUE    = 2'd1,
        PAIR_KEY_ONLY = 2'd2
    } t_pair;

    typedef enum logic {
        CMD_DATA   = 1'b0,
        CMD_FINISH = 1'b1
    } t_cmd;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
    } t_request;

    typedef struct packed {
        logic       finish_ok;
        logic       is_finished;
        logic       is_invalid;
        t_pair      pair_event;
        t_role      byte_role;
        logic [7:0] byte_out;
    } t_result;

endpackage

>>> sv/name_value_pair_tokenizer_unit.sv
`timescale 1ns / 1ps
// top level of the semicolon separated key=value tokenizer
// depends on nvpt_pkg, nvpt_in_reg, nvpt_step, nvpt_out_reg
//
//  port group     dir  tdata               tuser
//  s_axis_*       in   data_byte[7:0]      command[0]
//  m_axis_*       out  byte_out[7:0],      byte_role[1:0]
//                      pair_event[9:8], is_invalid[10],
//                      is_finished[11], finish_ok[12]
//  i_cfg_wr_*     in   allow_key_only[0]   -
//
// one request per cycle while the master side does not stall; each result shows on the master side
// once it has passed the input register, the parser step and then the result register
// synchronous active low reset: empty stages, phase skipping space before key,
// key flag and allow_key_only cleared
// a stalled result holds while one more request waits in the input register

module name_value_pair_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [9:8] pair_event,
                                        // [10] is_invalid, [11] is_finished,
                                        // [12] finish_ok, [15:13] zero
    output logic [1:0]  m_axis_tuser    // [1:0] byte_role
);

    logic               in_vld;
    logic               take;
    nvpt_pkg::t_request in_req;
    nvpt_pkg::t_phase   r_phase;
    nvpt_pkg::t_phase   n_phase;
    logic               r_key_seen;
    logic               n_key_seen;
    logic               r_allow_key_only;
    nvpt_pkg::t_result  step_res;
    logic               fire;

    assign fire = in_vld && take;

    nvpt_in_reg u_in_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_take        (take),
        .o_vld         (in_vld),
        .o_req         (in_req)
    );

    nvpt_step u_step (
        .i_phase          (r_phase),
        .i_key_seen       (r_key_seen),
        .i_allow_key_only (r_allow_key_only),
        .i_req            (in_req),
        .o_phase          (n_phase),
        .o_key_seen       (n_key_seen),
        .o_res            (step_res)
    );

    nvpt_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (in_vld),
        .i_res         (step_res),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= nvpt_pkg::PH_KEYSPACE;
            r_key_seen <= 1'b0;
        end else if (fire) begin
            r_phase    <= n_phase;
            r_key_seen <= n_key_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_key_only <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_allow_key_only <= i_cfg_wr_data;
        end
    end

    a_key_clear_between_pairs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == nvpt_pkg::PH_KEYSPACE || r_phase == nvpt_pkg::PH_AFTER ||
         r_phase == nvpt_pkg::PH_FINISHED) |-> !r_key_seen)
        else $error("key flag set outside a pending pair");

    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == nvpt_pkg::PH_FINISHED |=> r_phase == nvpt_pkg::PH_FINISHED)
        else $error("left finished phase");

    a_invalid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == nvpt_pkg::PH_INVALID |=> r_phase == nvpt_pkg::PH_INVALID)
        else $error("left invalid phase");

    a_ok_means_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[12]) |-> (m_axis_tdata[11] && !m_axis_tdata[10]))
        else $error("finish ok without finished phase");

    a_state_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> ($stable(r_phase) && $stable(r_key_seen)))
        else $error("parser state moved without a request");

endmodule

>>> sv/nvpt_in_reg.sv
`timescale 1ns / 1ps
// input register stage: holds one accepted request until the result register takes it
// depends on nvpt_pkg

module nvpt_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tuser,   // [0] command
    input  logic               i_take,
    output logic               o_vld,
    output nvpt_pkg::t_request o_req
);

    logic               r_vld;
    nvpt_pkg::t_request r_req;

    assign s_axis_tready = !r_vld || i_take;
    assign o_vld         = r_vld;
    assign o_req         = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_req.cmd       <= nvpt_pkg::t_cmd'(s_axis_tuser);
            r_req.data_byte <= s_axis_tdata;
        end
    end

endmodule

>>> sv/nvpt_step.sv
`timescale 1ns / 1ps
// per-byte parser step: next phase, key flag and result for one request
// depends on nvpt_pkg

module nvpt_step (
    input  nvpt_pkg::t_phase   i_phase,
    input  logic               i_key_seen,
    input  logic               i_allow_key_only,
    input  nvpt_pkg::t_request i_req,
    output nvpt_pkg::t_phase   o_phase,
    output logic               o_key_seen,
    output nvpt_pkg::t_result  o_res
);

    nvpt_pkg::t_phase n_phase;
    logic             n_key_seen;
    nvpt_pkg::t_role  n_role;
    nvpt_pkg::t_pair  n_pair;
    logic             n_ok;
    logic             do_key;
    logic             do_key_only;
    logic [7:0]       b;

    assign b = i_req.data_byte;

    always_comb begin
        n_phase     = i_phase;
        n_key_seen  = i_key_seen;
        n_role      = nvpt_pkg::ROLE_NONE;
        n_pair      = nvpt_pkg::PAIR_NONE;
        n_ok        = 1'b0;
        do_key      = 1'b0;
        do_key_only = 1'b0;

        if (i_req.cmd == nvpt_pkg::CMD_FINISH) begin
            unique case (i_phase)
                nvpt_pkg::PH_FINISHED: begin
                    n_ok = 1'b1;
                end
                nvpt_pkg::PH_KEY, nvpt_pkg::PH_EQSPACE, nvpt_pkg::PH_EQUAL: begin
                    if (i_allow_key_only && i_key_seen) begin
                        n_pair     = nvpt_pkg::PAIR_KEY_ONLY;
                        n_key_seen = 1'b0;
                        n_phase    = nvpt_pkg::PH_FINISHED;
                        n_ok       = 1'b1;
                    end else begin
                        n_phase = nvpt_pkg::PH_INVALID;
                    end
                end
                nvpt_pkg::PH_RAW: begin
                    n_pair     = nvpt_pkg::PAIR_VALUE;
                    n_key_seen = 1'b0;
                    n_phase    = nvpt_pkg::PH_FINISHED;
                    n_ok       = 1'b1;
                end
                nvpt_pkg::PH_KEYSPACE, nvpt_pkg::PH_AFTER: begin
                    n_phase = nvpt_pkg::PH_FINISHED;
                    n_ok    = 1'b1;
                end
                default: begin
                    n_phase = nvpt_pkg::PH_INVALID;
                end
            endcase
        end else begin
            unique case (i_phase)
                nvpt_pkg::PH_KEYSPACE: begin
                    do_key = (b > nvpt_pkg::CH_SPACE);
                end
                nvpt_pkg::PH_KEY: begin
                    do_key = 1'b1;
                end
                nvpt_pkg::PH_EQSPACE: begin
                    if (b == nvpt_pkg::CH_EQUAL) begin
                        n_phase = nvpt_pkg::PH_EQUAL;
                    end else if (b == nvpt_pkg::CH_SEMI) begin
                        do_key_only = 1'b1;
                    end else if (b > nvpt_pkg::CH_SPACE) begin
                        n_phase = nvpt_pkg::PH_INVALID;
                    end
                end
                nvpt_pkg::PH_EQUAL: begin
                    if (b == nvpt_pkg::CH_SEMI) begin
                        do_key_only = 1'b1;
                    end else if (b == nvpt_pkg::CH_DQUOTE) begin
                        n_phase = nvpt_pkg::PH_DQ;
                    end else if (b == nvpt_pkg::CH_SQUOTE) begin
                        n_phase = nvpt_pkg::PH_SQ;
                    end else begin
                        n_role  = nvpt_pkg::ROLE_VALUE;
                        n_phase = nvpt_pkg::PH_RAW;
                    end
                end
                nvpt_pkg::PH_DQ, nvpt_pkg::PH_SQ: begin
                    if ((i_phase == nvpt_pkg::PH_DQ && b == nvpt_pkg::CH_DQUOTE) ||
                        (i_phase == nvpt_pkg::PH_SQ && b == nvpt_pkg::CH_SQUOTE)) begin
                        n_pair     = nvpt_pkg::PAIR_VALUE;
                        n_key_seen = 1'b0;
                        n_phase    = nvpt_pkg::PH_AFTER;
                    end else begin
                        n_role = nvpt_pkg::ROLE_VALUE;
                    end
                end
                nvpt_pkg::PH_RAW: begin
                    if (b == nvpt_pkg::CH_SEMI) begin
                        n_pair     = nvpt_pkg::PAIR_VALUE;
                        n_key_seen = 1'b0;
                        n_phase    = nvpt_pkg::PH_KEYSPACE;
                    end else begin
                        n_role = nvpt_pkg::ROLE_VALUE;
                    end
                end
                nvpt_pkg::PH_AFTER: begin
                    if (b == nvpt_pkg::CH_SEMI) begin
                        n_phase = nvpt_pkg::PH_KEYSPACE;
                    end else if (b > nvpt_pkg::CH_SPACE) begin
                        n_phase = nvpt_pkg::PH_INVALID;
                    end
                end
                nvpt_pkg::PH_FINISHED: begin
                    n_phase = nvpt_pkg::PH_FINISHED;
                end
                default: begin
                    n_phase = nvpt_pkg::PH_INVALID;
                end
            endcase

            // key byte handling
            if (do_key) begin
                priority if (b == nvpt_pkg::CH_EQUAL) begin
                    n_phase = nvpt_pkg::PH_EQUAL;
                end else if (b <= nvpt_pkg::CH_SPACE) begin
                    n_phase = nvpt_pkg::PH_EQSPACE;
                end else if (b == nvpt_pkg::CH_SEMI) begin
                    do_key_only = 1'b1;
                end else if (b == nvpt_pkg::CH_DQUOTE || b == nvpt_pkg::CH_SQUOTE) begin
                    n_phase = nvpt_pkg::PH_INVALID;
                end else begin
                    n_role     = nvpt_pkg::ROLE_KEY;
                    n_key_seen = 1'b1;
                    n_phase    = nvpt_pkg::PH_KEY;
                end
            end

            if (do_key_only) begin
                if (i_allow_key_only) begin
                    n_pair     = nvpt_pkg::PAIR_KEY_ONLY;
                    n_key_seen = 1'b0;
                    n_phase    = nvpt_pkg::PH_KEYSPACE;
                end else begin
                    n_phase = nvpt_pkg::PH_INVALID;
                end
            end
        end
    end

    assign o_phase             = n_phase;
    assign o_key_seen          = n_key_seen;
    assign o_res.byte_out      = (n_role != nvpt_pkg::ROLE_NONE) ? b : 8'h00;
    assign o_res.byte_role     = n_role;
    assign o_res.pair_event    = n_pair;
    assign o_res.is_invalid    = (n_phase == nvpt_pkg::PH_INVALID);
    assign o_res.is_finished   = (n_phase == nvpt_pkg::PH_FINISHED);
    assign o_res.finish_ok     = n_ok;

endmodule

>>> sv/nvpt_out_reg.sv
`timescale 1ns / 1ps
// result register stage driving the master stream side
// depends on nvpt_pkg

module nvpt_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  nvpt_pkg::t_result i_res,
    output logic              o_take,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // [7:0] byte_out, [9:8] pair_event,
                                             // [10] is_invalid, [11] is_finished,
                                             // [12] finish_ok, [15:13] zero
    output logic [1:0]        m_axis_tuser   // [1:0] byte_role
);

    logic              r_vld;
    nvpt_pkg::t_result r_res;

    assign o_take        = !r_vld || m_axis_tready;
    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = {3'b000, r_res.finish_ok, r_res.is_finished, r_res.is_invalid,
                            r_res.pair_event, r_res.byte_out};
    assign m_axis_tuser  = r_res.byte_role;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_vld) begin
            r_res <= i_res;
        end
    end

endmodule
